/* rtl/pwa_pkg.sv */
// Package for the PWM pulse-width averager: payload structs, phase and
// sequencer encodings, and shared constants. No dependencies.
package pwa_pkg;

  // Default number of widths held in the averaging window.
  localparam int unsigned WINDOW_DEPTH_DEF = 50;
  // Reset value of the re-arm timeout, in microseconds.
  localparam logic [31:0] REARM_TIMEOUT_RST = 32'd3000;
  // Depth of the job queue between front and back, and its pointer width.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;

  // Capture phase of the pulse machine.
  typedef enum logic [1:0] {
    PH_WAIT = 2'd0,
    PH_HIGH = 2'd1,
    PH_LOW  = 2'd2
  } phase_e;

  // Sequencer states of the averaging back end.
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_READ,
    BK_UPDATE,
    BK_DIV,
    BK_OUT
  } back_state_e;

  // One polled pin sample.
  typedef struct packed {
    logic        pin_level;
    logic [31:0] time_us;
  } in_t;

  // One result transaction.
  typedef struct packed {
    logic        pulse_done;
    logic [31:0] pulse_width_us;
    logic [31:0] average_width_us;
    logic [5:0]  stored_count;
    logic [1:0]  phase;
  } out_t;

  // Classified sample handed from the front end to the back end.
  typedef struct packed {
    logic        done;
    logic [31:0] width;
    phase_e      phase;
  } job_t;

endpackage

/* rtl/pwa_front.sv */
// Front end of the PWM pulse-width averager: runs the capture phase machine
// on each accepted sample and emits a job. Depends on pwa_pkg.
module pwa_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [31:0]    cfg_wdata_i,
  input  logic           accept_i,
  input  pwa_pkg::in_t   in_i,
  output pwa_pkg::job_t  job_o
);
  import pwa_pkg::*;

  phase_e      phase_q, phase_d;
  logic [31:0] rise_q, fall_q, width_q, timeout_q;
  logic [31:0] since_fall, new_width;
  logic        capture_rise, capture_fall;

  assign since_fall = in_i.time_us - fall_q;
  assign new_width  = in_i.time_us - rise_q;

  // Next phase from the current phase and the sampled level.
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      PH_HIGH: begin
        if (!in_i.pin_level) phase_d = PH_LOW;
      end
      PH_LOW: begin
        if (since_fall > timeout_q) phase_d = PH_WAIT;
      end
      default: begin
        phase_d = in_i.pin_level ? PH_HIGH : PH_WAIT;
      end
    endcase
  end

  // Edge captures implied by the current phase.
  always_comb begin
    capture_rise = 1'b0;
    capture_fall = 1'b0;
    unique case (phase_q)
      PH_HIGH: capture_fall = !in_i.pin_level;
      PH_LOW:  ;
      default: capture_rise = in_i.pin_level;
    endcase
  end

  // Job describing what this sample did.
  always_comb begin
    job_o.done  = capture_fall;
    job_o.width = capture_fall ? new_width : width_q;
    job_o.phase = phase_d;
  end

  // Phase and timestamps advance on each accepted sample.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_WAIT;
      rise_q    <= '0;
      fall_q    <= '0;
      width_q   <= '0;
      timeout_q <= REARM_TIMEOUT_RST;
    end else begin
      if (cfg_we_i) timeout_q <= cfg_wdata_i;
      if (accept_i) begin
        phase_q <= phase_d;
        if (capture_rise) rise_q <= in_i.time_us;
        if (capture_fall) begin
          fall_q  <= in_i.time_us;
          width_q <= new_width;
        end
      end
    end
  end

endmodule

/* rtl/pwa_queue.sv */
// Short job queue between front and back ends of the PWM pulse-width
// averager. Depends on pwa_pkg.
module pwa_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_i,
  input  pwa_pkg::job_t  wr_data_i,
  output logic           full_o,
  input  logic           rd_i,
  output pwa_pkg::job_t  rd_data_o,
  output logic           empty_o
);
  import pwa_pkg::*;

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t              entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [CNT_W-1:0]  cnt_q;

  assign full_o    = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign rd_data_o = entry_q[rptr_q];

  // Pointer and occupancy bookkeeping.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (wr_i) wptr_q <= wptr_q + QPTR_W'(1);
      if (rd_i) rptr_q <= rptr_q + QPTR_W'(1);
      if (wr_i && !rd_i)      cnt_q <= cnt_q + CNT_W'(1);
      else if (rd_i && !wr_i) cnt_q <= cnt_q - CNT_W'(1);
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (wr_i) entry_q[wptr_q] <= wr_data_i;
  end

endmodule

/* rtl/pwa_back.sv */
// Back end of the PWM pulse-width averager: keeps the width ring and running
// sum, divides for the mean bit by bit and holds the result. Depends on pwa_pkg.
module pwa_back #(
  parameter int unsigned WINDOW_DEPTH = pwa_pkg::WINDOW_DEPTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_empty_i,
  input  pwa_pkg::job_t  q_data_i,
  output logic           q_rd_o,
  output logic           out_valid_o,
  input  logic           out_pop_i,
  output pwa_pkg::out_t  out_o
);
  import pwa_pkg::*;

  localparam int unsigned CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned SUM_W  = 32 + CNT_W;
  localparam int unsigned STEP_W = $clog2(SUM_W);

  back_state_e       state_q, state_d;
  job_t              job_q;
  logic [31:0]       ring_mem [WINDOW_DEPTH];
  logic [31:0]       old_q;
  logic [SLOT_W-1:0] slot_q;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [31:0]       mean_q;
  logic [SUM_W-1:0]  quo_q, quo_next;
  logic [CNT_W-1:0]  rem_q, rem_next;
  logic [CNT_W-1:0]  den_q;
  logic [STEP_W-1:0] step_q;
  logic [CNT_W:0]    trial;
  logic              ge;
  logic              win_full, out_valid_q, out_free;
  logic              mem_rd, do_update, div_step, out_load;
  out_t              out_q;

  assign win_full    = (count_q == CNT_W'(WINDOW_DEPTH));
  assign out_free    = !out_valid_q || out_pop_i;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // Next sequencer state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) state_d = q_data_i.done ? BK_READ : BK_OUT;
      end
      BK_READ:   state_d = BK_UPDATE;
      BK_UPDATE: state_d = BK_DIV;
      BK_DIV: begin
        if (step_q == '0) state_d = BK_OUT;
      end
      BK_OUT: begin
        if (out_free) state_d = BK_IDLE;
      end
      default:   state_d = BK_IDLE;
    endcase
  end

  // Sequencer strobes.
  always_comb begin
    q_rd_o    = 1'b0;
    mem_rd    = 1'b0;
    do_update = 1'b0;
    div_step  = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      BK_IDLE:   q_rd_o    = !q_empty_i;
      BK_READ:   mem_rd    = 1'b1;
      BK_UPDATE: do_update = 1'b1;
      BK_DIV:    div_step  = 1'b1;
      BK_OUT:    out_load  = out_free;
      default:   ;
    endcase
  end

  // Running sum and fill count after storing the new width.
  always_comb begin
    sum_d   = sum_q - (win_full ? SUM_W'(old_q) : '0) + SUM_W'(job_q.width);
    count_d = win_full ? count_q : count_q + CNT_W'(1);
  end

  // One restoring division step: shift in a dividend bit, subtract if it fits.
  always_comb begin
    trial    = {rem_q, quo_q[SUM_W-1]};
    ge       = (trial >= {1'b0, den_q});
    rem_next = ge ? CNT_W'(trial - {1'b0, den_q}) : trial[CNT_W-1:0];
    quo_next = {quo_q[SUM_W-2:0], ge};
  end

  // Control state and datapath registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      slot_q      <= '0;
      count_q     <= '0;
      sum_q       <= '0;
      mean_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (do_update) begin
        sum_q   <= sum_d;
        count_q <= count_d;
        slot_q  <= (slot_q == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : slot_q + SLOT_W'(1);
      end
      if (div_step && step_q == '0) mean_q <= quo_next[31:0];
      if (out_load)       out_valid_q <= 1'b1;
      else if (out_pop_i) out_valid_q <= 1'b0;
    end
  end

  // Payload registers: job, divider and result.
  always_ff @(posedge clk_i) begin
    if (q_rd_o) job_q <= q_data_i;
    if (do_update) begin
      quo_q  <= sum_d;
      rem_q  <= '0;
      den_q  <= count_d;
      step_q <= STEP_W'(SUM_W - 1);
    end else if (div_step) begin
      quo_q  <= quo_next;
      rem_q  <= rem_next;
      step_q <= step_q - STEP_W'(1);
    end
    if (out_load) begin
      out_q.pulse_done       <= job_q.done;
      out_q.pulse_width_us   <= job_q.width;
      out_q.average_width_us <= mean_q;
      out_q.stored_count     <= 6'(count_q);
      out_q.phase            <= 2'(job_q.phase);
    end
  end

  // Width ring: oldest entry read ahead of the update, new width written in.
  always_ff @(posedge clk_i) begin
    if (mem_rd)    old_q <= ring_mem[slot_q];
    if (do_update) ring_mem[slot_q] <= job_q.width;
  end

endmodule

/* rtl/pwm_pulse_width_averager_top.sv */
// Top level of the PWM pulse-width averager: front end, job queue and back end.
// Depends on pwa_pkg, pwa_front, pwa_queue and pwa_back.
//
//  Channel   Direction  Handshake                  Payload
//  sample    in         push / full                in_i  (pwa_pkg::in_t)
//  result    out        pop / empty                out_o (pwa_pkg::out_t)
//  config    in         cfg_we_i, no back-pressure cfg_wdata_i (re-arm timeout)
//
// A pulse-completing sample passes the back end's read, update, bit-serial
// mean division and output states; other samples go from idle to output. The
// front end takes a sample in every cycle until the two-entry job queue fills.
// The width ring needs no clearing after reset. A held result in the output
// register stalls the back end and, once the queue fills, the front end too.
module pwm_pulse_width_averager_top #(
  parameter int unsigned WINDOW_DEPTH = pwa_pkg::WINDOW_DEPTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  pwa_pkg::in_t  in_i,
  output logic          empty,
  input  logic          pop,
  output pwa_pkg::out_t out_o,
  input  logic          cfg_we_i,
  input  logic [31:0]   cfg_wdata_i
);
  import pwa_pkg::*;

  job_t front_job, q_job;
  logic q_full, q_empty, q_rd, accept, out_valid;

  // A sample transaction completes when the queue has room.
  assign full   = q_full;
  assign accept = push && !q_full;
  assign empty  = !out_valid;

  pwa_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .in_i        (in_i),
    .job_o       (front_job)
  );

  pwa_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (accept),
    .wr_data_i (front_job),
    .full_o    (q_full),
    .rd_i      (q_rd),
    .rd_data_o (q_job),
    .empty_o   (q_empty)
  );

  pwa_back #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_data_i    (q_job),
    .q_rd_o      (q_rd),
    .out_valid_o (out_valid),
    .out_pop_i   (pop),
    .out_o       (out_o)
  );

endmodule
